@@ hdl/assert_macros.svh @@
// Assertion macros for the block's RTL; included by dct8_ctrl.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DCT_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define DCT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/dct8_pkg.sv @@
// Types and constants of the 8x8 DCT / IDCT block.
// No dependencies; used by the controller, datapath and top level.
package dct8_pkg;

	localparam int N = 8;
	localparam int VAL_W = 16;
	localparam int MID_W = 32;
	localparam int PROD_W = 48;
	localparam int ACC_W = 51;
	localparam int MID_SHIFT = 4;
	localparam int FWD_SHIFT = 22;
	localparam int INV_SHIFT = 30;

	// Q1.14 cosine table, row k, column n
	localparam logic signed [15:0] COS_TAB [64] = '{
		16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585,
		16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585,
		16'sd16069, 16'sd13623, 16'sd9102, 16'sd3196,
		-16'sd3196, -16'sd9102, -16'sd13623, -16'sd16069,
		16'sd15137, 16'sd6270, -16'sd6270, -16'sd15137,
		-16'sd15137, -16'sd6270, 16'sd6270, 16'sd15137,
		16'sd13623, -16'sd3196, -16'sd16069, -16'sd9102,
		16'sd9102, 16'sd16069, 16'sd3196, -16'sd13623,
		16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585,
		16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585,
		16'sd9102, -16'sd16069, 16'sd3196, 16'sd13623,
		-16'sd13623, -16'sd3196, 16'sd16069, -16'sd9102,
		16'sd6270, -16'sd15137, 16'sd15137, -16'sd6270,
		-16'sd6270, 16'sd15137, -16'sd15137, 16'sd6270,
		16'sd3196, -16'sd9102, 16'sd13623, -16'sd16069,
		16'sd16069, -16'sd13623, 16'sd9102, -16'sd3196
	};

	typedef struct packed {
		logic       issue;
		logic       pass;
		logic       inv;
		logic [2:0] o;
		logic [2:0] m;
		logic [2:0] t;
		logic       ld_we;
		logic [5:0] ld_addr;
		logic       emit_rd;
		logic [5:0] emit_addr;
		logic       out_load;
		logic       out_last;
	} dct8_cmd_t;

	typedef struct packed {
		logic out_busy;
		logic out_taken;
	} dct8_stat_t;

endpackage

@@ hdl/dct8_ctrl.sv @@
// Sequencer of the 8x8 DCT / IDCT: load, two MAC passes, drain, emit.
// Depends on dct8_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dct8_ctrl import dct8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  dct8_stat_t stat,
	output dct8_cmd_t  cmd
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ERD   = 3'd3;
	localparam logic [2:0] ST_ELD   = 3'd4;
	localparam logic [2:0] ST_WAIT  = 3'd5;

	logic [2:0] state_q;
	logic [8:0] cnt_q;
	logic [1:0] drain_q;
	logic [5:0] fill_q;
	logic       pass_q;
	logic       mode_q;
	logic       inv_q;
	logic       in_acc;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			drain_q <= '0;
			fill_q <= '0;
			pass_q <= 1'b0;
			mode_q <= 1'b0;
			inv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							state_q <= ST_RUN;
							cnt_q <= '0;
							pass_q <= 1'b0;
							inv_q <= mode_q;
						end
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'd511) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd3) begin
						cnt_q <= '0;
						if (!pass_q) begin
							pass_q <= 1'b1;
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_ERD;
						end
					end
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (stat.out_taken) begin
						if (cnt_q[5:0] == 6'd63) begin
							state_q <= ST_LOAD;
						end else begin
							cnt_q <= cnt_q + 9'd1;
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.issue = (state_q == ST_RUN);
		cmd.pass = pass_q;
		cmd.inv = inv_q;
		cmd.o = cnt_q[8:6];
		cmd.m = cnt_q[5:3];
		cmd.t = cnt_q[2:0];
		cmd.ld_we = in_acc;
		cmd.ld_addr = fill_q;
		cmd.emit_rd = (state_q == ST_ERD);
		cmd.emit_addr = cnt_q[5:0];
		cmd.out_load = (state_q == ST_ELD);
		cmd.out_last = (cnt_q[5:0] == 6'd63);
	end

	`DCT_ASSERT(a_load_free, cmd.out_load, !stat.out_busy)
	`DCT_ASSERT_NXT(a_start_run, in_acc && fill_q == 6'd63,
		state_q == ST_RUN && cnt_q == 9'd0 && !pass_q)
	`DCT_ASSERT_NXT(a_emit_done, state_q == ST_WAIT && stat.out_taken && cnt_q[5:0] == 6'd63,
		state_q == ST_LOAD && fill_q == 6'd0)

endmodule

@@ hdl/dct8_dp.sv @@
// Datapath of the 8x8 DCT / IDCT: block and transpose memories, one MAC,
// rounding, saturation and the output register. Depends on dct8_pkg.
module dct8_dp import dct8_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dct8_cmd_t               cmd,
	output dct8_stat_t              stat,
	input  logic signed [VAL_W-1:0] din,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] out_data,
	output logic                    out_last
);

	localparam logic signed [ACC_W-1:0] FWD_HI = 51'sd32767;
	localparam logic signed [ACC_W-1:0] FWD_LO = -51'sd32768;
	localparam logic signed [ACC_W-1:0] INV_HI = 51'sd2047;
	localparam logic signed [ACC_W-1:0] INV_LO = -51'sd2048;

	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
			input int s);
		logic signed [ACC_W-1:0] h;
		logic signed [ACC_W-1:0] b;
		h = ACC_W'(1) <<< (s - 1);
		b = '0;
		b[0] = v[ACC_W-1];
		return (v + h - b) >>> s;
	endfunction

	logic signed [VAL_W-1:0] bmem [64];
	logic signed [MID_W-1:0] tmem [64];

	logic signed [VAL_W-1:0] brd_q;
	logic signed [MID_W-1:0] trd_q;
	logic [5:0]              b_raddr;
	logic [2:0]              row, col, mc;

	logic                    valid_s1, first_s1, last_s1, pass_s1, inv_s1;
	logic [5:0]              waddr_s1;
	logic signed [15:0]      coef_s1;
	logic                    valid_s2, first_s2, last_s2, pass_s2, inv_s2;
	logic [5:0]              waddr_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                    wb_s3, pass_s3, inv_s3;
	logic [5:0]              waddr_s3;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [MID_W-1:0] opnd;
	logic signed [VAL_W-1:0] clip;
	logic signed [ACC_W-1:0] r_mid, r_fwd, r_inv;
	logic signed [VAL_W-1:0] res16;
	logic                    out_valid_q, out_last_q;
	logic signed [VAL_W-1:0] out_data_q;

	assign b_raddr = cmd.emit_rd ? cmd.emit_addr : {cmd.o, cmd.t};
	assign mc = cmd.pass ? cmd.o : cmd.m;
	assign row = cmd.inv ? cmd.t : mc;
	assign col = cmd.inv ? mc : cmd.t;

	always_ff @(posedge clk) begin
		if (cmd.issue || cmd.emit_rd) begin
			brd_q <= bmem[b_raddr];
		end
		if (cmd.issue) begin
			trd_q <= tmem[{cmd.m, cmd.t}];
		end
		if (cmd.ld_we) begin
			bmem[cmd.ld_addr] <= din;
		end else if (wb_s3 && pass_s3) begin
			bmem[waddr_s3] <= res16;
		end
		if (wb_s3 && !pass_s3) begin
			tmem[waddr_s3] <= r_mid[MID_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			wb_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			wb_s3 <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (cmd.t == 3'd0);
		last_s1 <= (cmd.t == 3'd7);
		pass_s1 <= cmd.pass;
		inv_s1 <= cmd.inv;
		waddr_s1 <= cmd.pass ? {cmd.o, cmd.m} : {cmd.m, cmd.o};
		coef_s1 <= COS_TAB[{row, col}];
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		pass_s2 <= pass_s1;
		inv_s2 <= inv_s1;
		waddr_s2 <= waddr_s1;
		prod_s2 <= opnd * PROD_W'(coef_s1);
		pass_s3 <= pass_s2;
		inv_s3 <= inv_s2;
		waddr_s3 <= waddr_s2;
		if (valid_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		if (inv_s1) begin
			clip = brd_q;
		end else if (brd_q > 16'sd2047) begin
			clip = 16'sd2047;
		end else if (brd_q < -16'sd2048) begin
			clip = -16'sd2048;
		end else begin
			clip = brd_q;
		end
		opnd = pass_s1 ? trd_q : MID_W'(clip);
	end

	always_comb begin
		r_mid = rnd(acc_q, MID_SHIFT);
		r_fwd = rnd(acc_q, FWD_SHIFT);
		r_inv = rnd(acc_q, INV_SHIFT);
		if (inv_s3) begin
			if (r_inv > INV_HI) res16 = VAL_W'(INV_HI);
			else if (r_inv < INV_LO) res16 = VAL_W'(INV_LO);
			else res16 = r_inv[VAL_W-1:0];
		end else begin
			if (r_fwd > FWD_HI) res16 = VAL_W'(FWD_HI);
			else if (r_fwd < FWD_LO) res16 = VAL_W'(FWD_LO);
			else res16 = r_fwd[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= brd_q;
			out_last_q <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_last = out_last_q;
	assign stat.out_busy = out_valid_q;
	assign stat.out_taken = out_valid_q && out_ready;

endmodule

@@ hdl/dct_idct_8x8.sv @@
// Top level of the 8x8 forward / inverse DCT.
// Depends on dct8_pkg, dct8_ctrl and dct8_dp.
//
// channel   signals                                   request
// s_axis    tvalid tready tdata[15:0]=value_in        one input value
// m_axis    tvalid tready tdata[15:0]=value_out tlast one result, tlast=last_of_block
// cfg       cfg_we cfg_wdata=inverse_mode             mode write
//
// The block is loaded, then two MAC passes run on one multiplier, each followed by
// a drain; then each result is read, loaded into the output register and held until taken.
// Reset clears control and mode; memories hold no reset value.
// Input is taken only while loading; a stalled output holds the sequencer.
module dct_idct_8x8 import dct8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] value_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] value_out
	output logic        m_axis_tlast
);

	dct8_cmd_t  cmd;
	dct8_stat_t stat;
	logic signed [VAL_W-1:0] dout;

	dct8_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dct8_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.din       (signed'(s_axis_tdata)),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (dout),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = unsigned'(dout);

endmodule

@@ test/dct_idct_8x8_check.sv @@
// Checker for the 8x8 forward / inverse DCT: watches the input, output and
// mode channels, predicts each block's 64 results and compares them.
// Depends on dct8_pkg for the shift amounts.
`timescale 1ns / 100ps
module dct_idct_8x8_check import dct8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} coef_t;

	coef_t             expected_q[$];
	logic signed [15:0] samples [64];
	int                 fill;
	logic               mode;
	longint             ctab [8][8];

	function automatic longint rnd_shift(longint v, int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// cos(a*pi/16) in Q30 via series, matching the table build
	function automatic longint cos_q(int a);
		longint unsigned th, x2, term;
		longint s;
		th = (64'd3373259426 * a) / 16;
		x2 = (th * th) >> 30;
		term = 64'd1 << 30;
		s = term;
		for (int k = 1; k <= 11; k++) begin
			term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
			s = (k & 1) ? s - term : s + term;
		end
		return s;
	endfunction

	function automatic longint cos_m(int m);
		int r;
		r = m % 32;
		if (r <= 8) return cos_q(r);
		if (r <= 16) return -cos_q(16 - r);
		if (r <= 24) return -cos_q(r - 16);
		return cos_q(32 - r);
	endfunction

	initial begin
		longint c;
		for (int k = 0; k < 8; k++)
			for (int n = 0; n < 8; n++) begin
				c = cos_m((2 * n + 1) * k);
				if (k == 0) c = rnd_shift(c * 64'sd759250125, 30);
				ctab[k][n] = rnd_shift(c, 16);
			end
	end

	task automatic transform_block(logic inv);
		longint mid [64];
		longint acc, x, r;
		coef_t e;
		for (int i = 0; i < 8; i++)
			for (int v = 0; v < 8; v++) begin
				acc = 0;
				for (int j = 0; j < 8; j++) begin
					x = samples[i * 8 + j];
					if (inv) acc += x * ctab[j][v];
					else acc += clip(x, -2048, 2047) * ctab[v][j];
				end
				mid[v * 8 + i] = rnd_shift(acc, MID_SHIFT);
			end
		for (int u = 0; u < 8; u++)
			for (int v = 0; v < 8; v++) begin
				acc = 0;
				for (int i = 0; i < 8; i++)
					acc += (inv ? ctab[i][u] : ctab[u][i]) * mid[v * 8 + i];
				if (inv) r = clip(rnd_shift(acc, INV_SHIFT), -2048, 2047);
				else r = clip(rnd_shift(acc, FWD_SHIFT), -32768, 32767);
				e.value = r[15:0];
				e.last = (u == 7 && v == 7);
				expected_q.push_back(e);
			end
	endtask

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		fill = 0;
		mode = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		coef_t e;
		if (!arst_n) begin
			fill = 0;
			mode = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", m_axis_tdata, 16'h0);
				end else begin
					e = expected_q.pop_front();
					if (m_axis_tdata !== e.value) report("value", m_axis_tdata, e.value);
					if (m_axis_tlast !== e.last)
						report("tlast", {15'd0, m_axis_tlast}, {15'd0, e.last});
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				samples[fill] = s_axis_tdata;
				fill++;
				if (fill == 64) begin
					transform_block(mode);
					fill = 0;
				end
			end
			if (cfg_we) mode = cfg_wdata;
		end
		pending = expected_q.size();
	end

endmodule

@@ test/dct_idct_8x8_test.sv @@
// Testbench top for the 8x8 forward / inverse DCT: drives blocks in both
// modes with random gaps and stalls; dct_idct_8x8_check gives the failures.
// Depends on dct8_pkg, dct_idct_8x8 and dct_idct_8x8_check.
`timescale 1ns / 100ps
module dct_idct_8x8_test;
	import dct8_pkg::*;

	localparam int WATCH_LIMIT = 40000;

	logic        clk, arst_n;
	logic        cfg_we, cfg_wdata;
	logic        s_axis_tvalid, s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count, pending;
	int          idle_cycles;
	logic        stalls_on;

	dct_idct_8x8 u_dut (.*);

	dct_idct_8x8_check u_check (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// drop ready at random on the result side
	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			m_axis_tready = stalls_on ? ($urandom_range(0, 3) != 0) : 1'b1;
			if (stalls_on && $urandom_range(0, 60) == 0) begin
				m_axis_tready = 0;
				repeat ($urandom_range(10, 50)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_value(logic [15:0] v);
		int g;
		g = gap_len();
		repeat (g) @(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
	endtask

	task automatic drain_results();
		wait_idle();
		repeat (50) @(negedge clk);
	endtask

	task automatic set_mode(logic m);
		cfg_we <= 1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [15:0] rand_value(int kind, logic inv);
		case (kind)
			0: return $urandom;
			1: return inv ? 16'($signed($urandom_range(0, 1024)) - 512)
			              : 16'($signed($urandom_range(0, 511)) - 256);
			default: return inv ? 16'($signed($urandom_range(0, 65535)) - 32768)
			                    : 16'($signed($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	initial begin
		logic inv;
		int kind;
		idle_cycles = 0;
		stalls_on = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extreme samples forward, clipped
		for (int k = 0; k < 64; k++)
			send_value((k % 4 == 0) ? 16'h7FFF : (k % 4 == 1) ? 16'h8000 :
			           (k % 4 == 2) ? 16'h07FF : 16'hF800);
		drain_results();
		// inverse of full-scale DC and extremes, saturating
		set_mode(1);
		for (int k = 0; k < 64; k++)
			send_value(k == 0 ? 16'h7FFF : (k[0] ? 16'h8000 : 16'h7FFF));
		drain_results();
		// mode flips mid-block: mode at the last value decides
		for (int k = 0; k < 64; k++) begin
			if (k == 30) set_mode(0);
			send_value(rand_value(2, 0));
		end
		drain_results();

		stalls_on = 1;
		for (int b = 0; b < 3; b++) begin
			inv = $urandom_range(0, 1);
			wait_idle();
			set_mode(inv);
			kind = $urandom_range(0, 2);
			for (int k = 0; k < 64; k++) begin
				if (b == 1 && k == 20) set_mode(~inv);
				send_value(rand_value(kind, inv));
			end
			// after the first block, hold input until all its results are out
			if (b == 0) drain_results();
			if (b == 0) stalls_on = 0;
			if (b == 1) stalls_on = 1;
		end
		drain_results();

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
